@@ sv/crsm_pkg.sv @@
// Shared constants and types for the circular range sum block.
package crsm_pkg;

  localparam int MAX_ELEMS  = 1024;
  localparam int ELEM_WIDTH = 16;
  localparam int ADDR_W     = $clog2(MAX_ELEMS);
  localparam int LEN_W      = 11;
  localparam int POS_W      = 10;
  localparam int VAL_W      = 16;
  localparam int SUM_W      = 27;
  localparam int BEST_W     = 26;
  localparam int CMD_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_RESULT
  } state_t;

endpackage

@@ sv/crsm_ram.sv @@
// Generic single-port RAM with registered read data.
module crsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/circular_range_sum_max_top.sv @@
// Circular range sum over a stored element array with a running best sum.
// Write and clear commands take effect at the accept edge; busy stays low.
// A query over N elements streams one element per cycle from a single RAM port:
// busy stays high through FETCH, DRAIN and RESULT, and out_valid is registered from RESULT.
// A query with a position at or beyond the length goes straight to RESULT and strobes out_valid.
// Synchronous reset clears control, the best sum and sets the length to 1024;
// the element RAM is not cleared and holds no defined value until written.
module circular_range_sum_max_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [crsm_pkg::CMD_W-1:0]             in_cmd,
  input  logic [crsm_pkg::POS_W-1:0]             in_elem_index,
  input  logic signed [crsm_pkg::VAL_W-1:0]      in_elem_value,
  input  logic [crsm_pkg::POS_W-1:0]             in_start_pos,
  input  logic [crsm_pkg::POS_W-1:0]             in_end_pos,
  input  logic                                   in_last_query,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [crsm_pkg::LEN_W-1:0]             cfg_data,
  output logic                                   out_valid,
  output logic signed [crsm_pkg::SUM_W-1:0]      out_range_sum,
  output logic [crsm_pkg::BEST_W-1:0]            out_best_sum,
  output logic [crsm_pkg::POS_W-1:0]             out_best_start,
  output logic [crsm_pkg::POS_W-1:0]             out_best_end,
  output logic                                   out_range_error,
  output logic                                   out_is_final
);

  import crsm_pkg::*;

  state_t                  state_r, state_nxt;
  logic [ADDR_W-1:0]       ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]       end_r, end_nxt;
  logic [ADDR_W-1:0]       last_r, last_nxt;
  logic [POS_W-1:0]        qstart_r, qstart_nxt;
  logic [POS_W-1:0]        qend_r, qend_nxt;
  logic                    err_r, err_nxt;
  logic                    final_r, final_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic [BEST_W-1:0]       best_r, best_nxt;
  logic [POS_W-1:0]        best_first_r, best_first_nxt;
  logic [POS_W-1:0]        best_last_r, best_last_nxt;
  logic [LEN_W-1:0]        len_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] o_sum_r, o_sum_nxt;
  logic [BEST_W-1:0]       o_best_r, o_best_nxt;
  logic [POS_W-1:0]        o_first_r, o_first_nxt;
  logic [POS_W-1:0]        o_last_r, o_last_nxt;
  logic                    o_err_r, o_err_nxt;
  logic                    o_final_r, o_final_nxt;

  logic                    accept;
  cmd_t                    cmd;
  logic [LEN_W-1:0]        len_eff;
  logic [LEN_W-1:0]        len_m1;
  logic                    q_err;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_addr;
  logic [ELEM_WIDTH-1:0]   ram_wdata;
  logic [ELEM_WIDTH-1:0]   ram_rdata;
  logic                    better;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cmd       = cmd_t'(in_cmd);
  assign cfg_ready = 1'b1;
  assign len_eff   = (len_r > LEN_W'(MAX_ELEMS)) ? LEN_W'(MAX_ELEMS) : len_r;
  assign len_m1    = len_eff - LEN_W'(1);
  assign q_err     = ({1'b0, in_start_pos} >= len_eff) || ({1'b0, in_end_pos} >= len_eff);
  assign better    = !err_r && (acc_r > 0) &&
                     (acc_r > $signed({{(SUM_W-BEST_W){1'b0}}, best_r}));

  crsm_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (MAX_ELEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && cmd == CMD_QUERY) begin
          state_nxt = q_err ? ST_RESULT : ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (ptr_r == end_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_RESULT;
      ST_RESULT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = accept && (cmd == CMD_WRITE);
    ram_addr  = (state_r == ST_FETCH) ? ptr_r : ADDR_W'(in_elem_index);
    ram_wdata = ELEM_WIDTH'(in_elem_value);
  end

  always_comb begin
    ptr_nxt        = ptr_r;
    end_nxt        = end_r;
    last_nxt       = last_r;
    qstart_nxt     = qstart_r;
    qend_nxt       = qend_r;
    err_nxt        = err_r;
    final_nxt      = final_r;
    acc_nxt        = acc_r;
    best_nxt       = best_r;
    best_first_nxt = best_first_r;
    best_last_nxt  = best_last_r;
    rd_vld_nxt     = (state_r == ST_FETCH);
    out_valid_nxt  = (state_r == ST_RESULT);
    o_sum_nxt      = o_sum_r;
    o_best_nxt     = o_best_r;
    o_first_nxt    = o_first_r;
    o_last_nxt     = o_last_r;
    o_err_nxt      = o_err_r;
    o_final_nxt    = o_final_r;

    if (rd_vld_r) begin
      acc_nxt = acc_r + SUM_W'($signed(ram_rdata));
    end

    if (state_r == ST_FETCH) begin
      if ({1'b0, ptr_r} == {1'b0, last_r}) begin
        ptr_nxt = '0;
      end else begin
        ptr_nxt = ptr_r + ADDR_W'(1);
      end
    end

    if (accept && cmd == CMD_QUERY) begin
      ptr_nxt    = ADDR_W'(in_start_pos);
      end_nxt    = ADDR_W'(in_end_pos);
      last_nxt   = ADDR_W'(len_m1);
      qstart_nxt = in_start_pos;
      qend_nxt   = in_end_pos;
      err_nxt    = q_err;
      final_nxt  = in_last_query;
      acc_nxt    = '0;
    end

    if (accept && cmd == CMD_CLEAR) begin
      best_nxt       = '0;
      best_first_nxt = '0;
      best_last_nxt  = '0;
    end

    if (state_r == ST_RESULT) begin
      if (better) begin
        best_nxt       = BEST_W'(acc_r);
        best_first_nxt = qstart_r;
        best_last_nxt  = qend_r;
      end
      o_sum_nxt   = err_r ? '0 : acc_r;
      o_best_nxt  = better ? BEST_W'(acc_r) : best_r;
      o_first_nxt = better ? qstart_r : best_first_r;
      o_last_nxt  = better ? qend_r : best_last_r;
      o_err_nxt   = err_r;
      o_final_nxt = final_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      best_r       <= '0;
      best_first_r <= '0;
      best_last_r  <= '0;
      len_r        <= LEN_W'(1024);
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      best_r       <= best_nxt;
      best_first_r <= best_first_nxt;
      best_last_r  <= best_last_nxt;
      if (cfg_valid && cfg_ready) begin
        len_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    end_r     <= end_nxt;
    last_r    <= last_nxt;
    qstart_r  <= qstart_nxt;
    qend_r    <= qend_nxt;
    err_r     <= err_nxt;
    final_r   <= final_nxt;
    acc_r     <= acc_nxt;
    o_sum_r   <= o_sum_nxt;
    o_best_r  <= o_best_nxt;
    o_first_r <= o_first_nxt;
    o_last_r  <= o_last_nxt;
    o_err_r   <= o_err_nxt;
    o_final_r <= o_final_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_range_sum   = o_sum_r;
  assign out_best_sum    = o_best_r;
  assign out_best_start  = o_first_r;
  assign out_best_end    = o_last_r;
  assign out_range_error = o_err_r;
  assign out_is_final    = o_final_r;

  a_strobe_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_RESULT))
    else $error("result strobe without a finished query");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ram_we)
    else $error("element write while a query runs");

  a_ptr_in_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> (ptr_r <= last_r))
    else $error("fetch address beyond array length");

  a_error_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> (out_range_sum == '0))
    else $error("range error with nonzero sum");

  a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> rd_vld_r)
    else $error("last element read missing at drain");

endmodule
